// ===== rtl/core/mbb_pkg.sv =====
// ----------------------------------------------------------------------------
// mbb_pkg: shared constants for the masked 3x3 box filter
// Register codes, configuration widths and the reciprocal table.
// ----------------------------------------------------------------------------
package mbb_pkg;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int RECIP_W    = 17;
  localparam int ROUND_BIAS = 32768;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] SIZE_MIN     = 11'd3;
  localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;
  localparam logic [CFG_W-1:0] SIZE_RESET   = 11'd256;

  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13107;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9362;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mbb_ram.sv =====
// ----------------------------------------------------------------------------
// mbb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mbb_ram #(
  parameter int WIDTH = 98,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/masked_box_blur_3x3_top.sv =====
// ----------------------------------------------------------------------------
// masked_box_blur_3x3_top: masked 3x3 box filter over a streamed lightmap
// Line-buffered averaging of valid texels with border pass-through.
// ----------------------------------------------------------------------------
// Texels enter in raster order; each result leaves frame_width+1 texels after
// its own texel, and flush words drain owed results. Both line stores share one
// RAM word per column, so every item does one read and at most one write of
// that RAM, one item at a time: a new word is accepted only once the previous
// item, including any wait on the output register, is done. After reset a
// clearing pass zeroes all MAX_WIDTH words of the line stores, during which no
// word is accepted.
module masked_box_blur_3x3_top #(
  parameter int MAX_WIDTH    = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [CHANNEL_BITS-1:0]          red_in,
  input  logic [CHANNEL_BITS-1:0]          green_in,
  input  logic [CHANNEL_BITS-1:0]          blue_in,
  input  logic                             texel_valid,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [CHANNEL_BITS-1:0]          red_out,
  output logic [CHANNEL_BITS-1:0]          green_out,
  output logic [CHANNEL_BITS-1:0]          blue_out,
  output logic                             valid_out,
  output logic                             frame_last,
  input  logic                             cfg_we,
  input  logic [mbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbb_pkg::CFG_W-1:0]        cfg_data
);
  import mbb_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int TW    = 3 * CB + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CNT_W = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int SUM_W = CB + 4;
  localparam int PRD_W = SUM_W + RECIP_W + 1;
  localparam int Q_W   = PRD_W - 16;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DATA, S_SUM, S_MUL, S_EMIT} state_t;

  state_t              state;
  logic [CW-1:0]       clr_addr;
  logic [CFG_W-1:0]    frame_width, frame_height;
  logic [CNT_W-1:0]    in_col, out_col;
  logic [CFG_W-1:0]    out_row;
  logic [CNT_W:0]      owed;
  logic                hold_kind, flush_upper;
  logic [TW-1:0]       hold_tex;
  logic [CW-1:0]       op_col;
  logic [TW-1:0]       win [9];
  logic [TW-1:0]       centre;
  logic [SUM_W-1:0]    sum_r, sum_g, sum_b;
  logic [3:0]          cnt;
  logic                interior;
  logic [CB-1:0]       res_r, res_g, res_b;

  logic                ram_we;
  logic [CW-1:0]       ram_waddr, ram_raddr;
  logic [2*TW-1:0]     ram_wdata, ram_rdata;

  logic [CNT_W-1:0]    fw_c;
  logic [CNT_W+1:0]    fl_t;
  logic [CNT_W-1:0]    flush_col;
  logic                in_acc;
  logic [SUM_W-1:0]    sr_c, sg_c, sb_c;
  logic [3:0]          n_c;
  logic [PRD_W-1:0]    pr, pg, pb;
  logic [Q_W-1:0]      qr, qg, qb;

  assign fw_c     = CNT_W'(frame_width);
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    fl_t = '0;
    flush_col = '0;
    if (owed <= {1'b0, fw_c}) begin
      fl_t = {2'b00, in_col} + {2'b00, fw_c} - {1'b0, owed};
      if (fl_t >= {2'b00, fw_c}) begin
        fl_t = fl_t - {2'b00, fw_c};
      end
      flush_col = fl_t[CNT_W-1:0];
    end else if (in_col == '0) begin
      flush_col = fw_c - CNT_W'(1);
    end else begin
      flush_col = in_col - CNT_W'(1);
    end
  end

  assign ram_raddr = kind ? flush_col[CW-1:0] : in_col[CW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op_col;
    ram_wdata = {ram_rdata[TW-1:0], hold_tex};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_DATA && !hold_kind) begin
      ram_we = 1'b1;
    end
  end

  mbb_ram #(.WIDTH(2 * TW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sr_c = '0;
    sg_c = '0;
    sb_c = '0;
    n_c  = '0;
    for (int i = 0; i < 9; i++) begin
      if (win[i][TW-1]) begin
        sr_c = sr_c + SUM_W'(win[i][3*CB-1:2*CB]);
        sg_c = sg_c + SUM_W'(win[i][2*CB-1:CB]);
        sb_c = sb_c + SUM_W'(win[i][CB-1:0]);
        n_c  = n_c + 4'd1;
      end
    end
  end

  assign pr = PRD_W'(sum_r) * PRD_W'(recip(cnt)) + PRD_W'(ROUND_BIAS);
  assign pg = PRD_W'(sum_g) * PRD_W'(recip(cnt)) + PRD_W'(ROUND_BIAS);
  assign pb = PRD_W'(sum_b) * PRD_W'(recip(cnt)) + PRD_W'(ROUND_BIAS);
  assign qr = pr[PRD_W-1:16];
  assign qg = pg[PRD_W-1:16];
  assign qb = pb[PRD_W-1:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      frame_width  <= SIZE_RESET;
      frame_height <= SIZE_RESET;
      in_col       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      owed         <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          if (cfg_data < SIZE_MIN) begin
            frame_width <= SIZE_MIN;
          end else if (CNT_W'(cfg_data) > CNT_W'(MAX_WIDTH)) begin
            frame_width <= CFG_W'(MAX_WIDTH);
          end else begin
            frame_width <= cfg_data;
          end
        end else begin
          if (cfg_data < SIZE_MIN) begin
            frame_height <= SIZE_MIN;
          end else if (cfg_data > HEIGHT_LIMIT) begin
            frame_height <= HEIGHT_LIMIT;
          end else begin
            frame_height <= cfg_data;
          end
        end
        in_col  <= '0;
        out_col <= '0;
        out_row <= '0;
        owed    <= '0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CW'(1);
          if (clr_addr == CW'(MAX_WIDTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            hold_kind   <= kind;
            hold_tex    <= {texel_valid, red_in, green_in, blue_in};
            op_col      <= in_col[CW-1:0];
            flush_upper <= (owed > {1'b0, fw_c});
            if (!kind || owed != '0) begin
              state <= S_DATA;
            end
          end
        end
        S_DATA: begin
          if (hold_kind) begin
            centre <= flush_upper ? ram_rdata[2*TW-1:TW] : ram_rdata[TW-1:0];
            res_r  <= flush_upper ? ram_rdata[TW+3*CB-1:TW+2*CB] : ram_rdata[3*CB-1:2*CB];
            res_g  <= flush_upper ? ram_rdata[TW+2*CB-1:TW+CB] : ram_rdata[2*CB-1:CB];
            res_b  <= flush_upper ? ram_rdata[TW+CB-1:TW] : ram_rdata[CB-1:0];
            owed   <= owed - (CNT_W+1)'(1);
            state  <= S_EMIT;
          end else begin
            for (int r = 0; r < 3; r++) begin
              win[r*3]   <= win[r*3+1];
              win[r*3+1] <= win[r*3+2];
            end
            win[2] <= ram_rdata[2*TW-1:TW];
            win[5] <= ram_rdata[TW-1:0];
            win[8] <= hold_tex;
            if (in_col + CNT_W'(1) >= fw_c) begin
              in_col <= '0;
            end else begin
              in_col <= in_col + CNT_W'(1);
            end
            if (owed >= {1'b0, fw_c} + (CNT_W+1)'(1)) begin
              centre <= win[5];
              state  <= S_SUM;
            end else begin
              owed  <= owed + (CNT_W+1)'(1);
              state <= S_IDLE;
            end
          end
        end
        S_SUM: begin
          sum_r    <= sr_c;
          sum_g    <= sg_c;
          sum_b    <= sb_c;
          cnt      <= n_c;
          interior <= (out_col != '0) && (out_col + CNT_W'(2) <= fw_c) &&
                      (out_row != '0) && ({1'b0, out_row} + 12'd2 <= {1'b0, frame_height});
          state    <= S_MUL;
        end
        S_MUL: begin
          if (interior && cnt != '0) begin
            res_r <= (qr[Q_W-1:CB] != '0) ? {CB{1'b1}} : qr[CB-1:0];
            res_g <= (qg[Q_W-1:CB] != '0) ? {CB{1'b1}} : qg[CB-1:0];
            res_b <= (qb[Q_W-1:CB] != '0) ? {CB{1'b1}} : qb[CB-1:0];
          end else begin
            res_r <= centre[3*CB-1:2*CB];
            res_g <= centre[2*CB-1:CB];
            res_b <= centre[CB-1:0];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            red_out   <= res_r;
            green_out <= res_g;
            blue_out  <= res_b;
            valid_out <= centre[TW-1];
            if (out_col + CNT_W'(1) >= fw_c) begin
              out_col <= '0;
              if (out_row + CFG_W'(1) >= frame_height) begin
                out_row    <= '0;
                frame_last <= 1'b1;
              end else begin
                out_row    <= out_row + CFG_W'(1);
                frame_last <= 1'b0;
              end
            end else begin
              out_col    <= out_col + CNT_W'(1);
              frame_last <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
